### rtl/midi_loop_track_sequencer_assert.svh
// assertion macros for the loop track sequencer
// used by the top level only
`ifndef MIDI_LOOP_TRACK_SEQUENCER_ASSERT_SVH
`define MIDI_LOOP_TRACK_SEQUENCER_ASSERT_SVH
`define MLT_ASSERT_IMPLY(label, a, b) \
   label: assert property (@(posedge clock) disable iff (reset) (a) |-> (b)) \
      else $error("assertion failed");
`define MLT_ASSERT_NEXT(label, a, b) \
   label: assert property (@(posedge clock) disable iff (reset) (a) |=> (b)) \
      else $error("assertion failed");
`endif

### rtl/mltseq_pkg.sv
// shared types and constants of the loop track sequencer
// no dependencies
package mltseq_pkg;
   localparam int PHASE_BITS     = 16;
   localparam int REC_BITS       = 9;
   localparam logic [15:0] DEFAULT_PERIOD = 16'((48000 * 2) / 64);
   localparam logic [7:0]  CC_STATUS = 8'hB0;
   localparam logic [7:0]  CC_FIRST  = 8'd23;
   localparam logic [7:0]  CC_LAST   = 8'd31;

   typedef enum logic [1:0] {
      MODE_TICK   = 2'd0,
      MODE_MIDI   = 2'd1,
      MODE_CLEAR  = 2'd2,
      MODE_PERIOD = 2'd3
   } mode_type;

   typedef struct packed {
      logic [15:0] rel;
      logic [1:0]  size;
      logic [3:0]  port;
      logic [7:0]  a;
      logic [7:0]  b;
      logic [7:0]  c;
   } entry_type;
endpackage

### rtl/mltseq_evs.sv
// event store memory, one write and one registered read port
// depends on mltseq_pkg
module mltseq_evs #(
   parameter int DEPTH = 576,
   parameter int AW = 10
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [AW-1:0]         wr_addr,
   input  mltseq_pkg::entry_type wr_data,
   input  logic                  rd_en,
   input  logic [AW-1:0]         rd_addr,
   output mltseq_pkg::entry_type rd_data
);
   mltseq_pkg::entry_type mem [DEPTH];
   mltseq_pkg::entry_type rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_ff;
endmodule

### rtl/mltseq_div.sv
// serial restoring divider, 32 by 16 bits, one quotient bit a cycle
// no dependencies
module mltseq_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [15:0] divisor,
   output logic        busy,
   output logic        done,
   output logic [15:0] quotient,
   output logic [15:0] remainder
);
   logic [31:0] q_ff, q_in;
   logic [15:0] r_ff, r_in;
   logic [15:0] d_ff;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [16:0] trial;

   always_comb begin
      trial   = {r_ff, q_ff[31]} - {1'b0, d_ff};
      q_in    = q_ff;
      r_in    = r_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (busy_ff) begin
         if (trial[16]) begin
            r_in = {r_ff[14:0], q_ff[31]};
            q_in = {q_ff[30:0], 1'b0};
         end else begin
            r_in = trial[15:0];
            q_in = {q_ff[30:0], 1'b1};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (start) begin
         q_in    = dividend;
         r_in    = '0;
         cnt_in  = 6'd32;
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
   end

   always_ff @(posedge clock) begin
      if (!busy_ff && start) begin
         d_ff <= divisor;
      end
   end

   assign busy      = busy_ff;
   assign done      = done_ff;
   assign quotient  = q_ff[15:0];
   assign remainder = r_ff;
endmodule

### rtl/midi_loop_track_sequencer.sv
// tick: walks queue entries, stalls on results, divides on a phase wrap
// midi in: checks each track in turn, serial divide per recording track
// clear and set period are done in the idle state; one request is worked on at a time
// results leave through an output register and a one-entry pending stage
// synchronous active-high reset clears indices, phases, periods to 1500, record bits
module midi_loop_track_sequencer #(
   parameter int NUM_TRACKS  = 9,
   parameter int QUEUE_DEPTH = 64,
   parameter int NUM_PORTS   = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_mode,
   input  logic [3:0]  req_track_sel,
   input  logic [3:0]  req_in_port,
   input  logic [7:0]  req_midi_size,
   input  logic [7:0]  req_byte_a,
   input  logic [7:0]  req_byte_b,
   input  logic [7:0]  req_byte_c,
   input  logic [15:0] req_new_period,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_play_track,
   output logic [3:0]  rsp_play_port,
   output logic [1:0]  rsp_play_size,
   output logic [7:0]  rsp_play_a,
   output logic [7:0]  rsp_play_b,
   output logic [7:0]  rsp_play_c,
   output logic        rsp_last
);
`include "midi_loop_track_sequencer_assert.svh"
   localparam int TW    = (NUM_TRACKS > 1) ? $clog2(NUM_TRACKS) : 1;
   localparam int QW    = $clog2(QUEUE_DEPTH);
   localparam int DEPTH = NUM_TRACKS * QUEUE_DEPTH;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NREC  = (NUM_TRACKS < mltseq_pkg::REC_BITS) ? NUM_TRACKS
                                                             : mltseq_pkg::REC_BITS;

   typedef enum logic [3:0] {
      S_IDLE, S_RD, S_WAIT, S_CMP, S_FLUSH, S_PH, S_PHDIV,
      S_REC_CHK, S_REC_DIV, S_CC
   } state_type;

   state_type state_ff;
   logic [TW-1:0] trk_ff;
   logic [QW:0]   n_ff;
   logic [3:0]    port_ff;
   logic [1:0]    size_ff;
   logic [7:0]    a_ff, b_ff, c_ff;
   logic [31:0]   prod_ff;
   logic [QW-1:0] head_ff [NUM_TRACKS];
   logic [QW-1:0] tail_ff [NUM_TRACKS];
   logic [15:0]   phase_ff [NUM_TRACKS];
   logic [15:0]   period_ff [NUM_TRACKS];
   logic [mltseq_pkg::REC_BITS-1:0] rec_ff;
   logic          cc_ff, ccv_ff;
   logic [3:0]    ccbit_ff;
   mltseq_pkg::entry_type pend_ff, out_ff;
   logic [3:0]    out_trk_ff;
   logic          pend_valid_ff, rsp_valid_ff, last_ff;

   logic [TW-1:0] sel_trk;
   logic [QW-1:0] cur_head, cur_tail, nxt_head, nxt_tail;
   logic [QW:0]   cur_count;
   logic [15:0]   cur_phase, cur_period;
   logic [16:0]   phase_inc;
   logic          out_free, out_load;
   logic          wr_en, rd_en, div_start, div_busy, div_done;
   logic [AW-1:0] rd_addr, wr_addr;
   mltseq_pkg::entry_type wr_data, rd_data, rec_entry;
   logic [31:0]   div_dividend;
   logic [15:0]   div_q, div_r;
   logic          rec_ok;

   always_comb begin
      sel_trk = '0;
      for (int i = 0; i < 16; i++) begin
         if (req_track_sel == 4'(i)) begin
            sel_trk = TW'(i % NUM_TRACKS);
         end
      end
   end

   assign cur_head   = head_ff[trk_ff];
   assign cur_tail   = tail_ff[trk_ff];
   assign cur_phase  = phase_ff[trk_ff];
   assign cur_period = period_ff[trk_ff];
   assign nxt_head   = (32'(cur_head) + 1 >= QUEUE_DEPTH) ? '0 : cur_head + 1'b1;
   assign nxt_tail   = (32'(cur_tail) + 1 >= QUEUE_DEPTH) ? '0 : cur_tail + 1'b1;
   assign cur_count  = (cur_tail >= cur_head) ? ({1'b0, cur_tail} - {1'b0, cur_head})
                     : ({1'b0, cur_tail} + (QW+1)'(QUEUE_DEPTH) - {1'b0, cur_head});
   assign phase_inc  = {1'b0, cur_phase} + 17'd1;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign out_load   = out_free && pend_valid_ff &&
                       ((state_ff == S_CMP && prod_ff[31:16] == cur_phase) ||
                        state_ff == S_FLUSH);
   assign rec_ok     = rec_ff[trk_ff] && (32'(cur_count) < QUEUE_DEPTH - 1);

   assign rd_en   = (state_ff == S_RD);
   assign rd_addr = AW'(32'(trk_ff) * QUEUE_DEPTH + 32'(cur_head));
   assign wr_addr = AW'(32'(trk_ff) * QUEUE_DEPTH + 32'(cur_tail));

   always_comb begin
      rec_entry      = '0;
      rec_entry.rel  = div_q;
      rec_entry.size = size_ff;
      rec_entry.port = port_ff;
      rec_entry.a    = (size_ff >= 2'd1) ? a_ff : 8'd0;
      rec_entry.b    = (size_ff >= 2'd2) ? b_ff : 8'd0;
      rec_entry.c    = (size_ff == 2'd3) ? c_ff : 8'd0;
   end

   assign wr_en   = (state_ff == S_CMP && prod_ff[31:16] == cur_phase &&
                     (!pend_valid_ff || out_free)) ||
                    (state_ff == S_REC_DIV && div_done);
   assign wr_data = (state_ff == S_CMP) ? rd_data : rec_entry;

   assign div_start    = (state_ff == S_PH && {1'b0, cur_period} <= phase_inc) ||
                         (state_ff == S_REC_CHK && rec_ok);
   assign div_dividend = (state_ff == S_PH) ? {15'd0, phase_inc} : {cur_phase, 16'd0};

   mltseq_evs #(.DEPTH(DEPTH), .AW(AW)) u_evs (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   mltseq_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (cur_period),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_q),
      .remainder(div_r)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         trk_ff        <= '0;
         rec_ff        <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         for (int t = 0; t < NUM_TRACKS; t++) begin
            head_ff[t]   <= '0;
            tail_ff[t]   <= '0;
            phase_ff[t]  <= '0;
            period_ff[t] <= mltseq_pkg::DEFAULT_PERIOD;
         end
      end else begin
         if (rsp_valid_ff && rsp_ready && !out_load) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  trk_ff   <= (req_mode == 2'(mltseq_pkg::MODE_MIDI)) ? '0 : sel_trk;
                  port_ff  <= req_in_port;
                  size_ff  <= req_midi_size[1:0];
                  a_ff     <= req_byte_a;
                  b_ff     <= req_byte_b;
                  c_ff     <= req_byte_c;
                  cc_ff    <= (req_in_port == 4'd0) && (req_midi_size == 8'd3) &&
                              (req_byte_a == mltseq_pkg::CC_STATUS) &&
                              (req_byte_b inside {[mltseq_pkg::CC_FIRST:
                                                   mltseq_pkg::CC_LAST]});
                  ccv_ff   <= (req_byte_c != 8'd0);
                  ccbit_ff <= 4'(req_byte_b - mltseq_pkg::CC_FIRST);
                  case (mltseq_pkg::mode_type'(req_mode))
                     mltseq_pkg::MODE_TICK: begin
                        n_ff     <= '0;
                        state_ff <= S_RD;
                     end
                     mltseq_pkg::MODE_MIDI: begin
                        if (32'(req_in_port) < NUM_PORTS) begin
                           if (req_midi_size < 8'd4) begin
                              state_ff <= S_REC_CHK;
                           end else begin
                              state_ff <= S_CC;
                           end
                        end
                     end
                     mltseq_pkg::MODE_CLEAR: begin
                        head_ff[sel_trk] <= '0;
                        tail_ff[sel_trk] <= '0;
                     end
                     default: begin
                        if (req_new_period != 16'd0) begin
                           period_ff[sel_trk] <= req_new_period;
                        end
                     end
                  endcase
               end
            end
            S_RD: begin
               if (n_ff == '0 && state_ff == S_RD) begin
                  n_ff <= cur_count;
               end
               state_ff <= (cur_count == '0) ? S_FLUSH : S_WAIT;
            end
            S_WAIT: begin
               prod_ff  <= 32'(cur_period) * 32'(rd_data.rel);
               state_ff <= S_CMP;
            end
            S_CMP: begin
               if (prod_ff[31:16] != cur_phase) begin
                  state_ff <= S_FLUSH;
               end else if (!pend_valid_ff || out_free) begin
                  if (pend_valid_ff) begin
                     out_ff       <= pend_ff;
                     out_trk_ff   <= 4'(trk_ff);
                     last_ff      <= 1'b0;
                     rsp_valid_ff <= 1'b1;
                  end
                  pend_ff         <= rd_data;
                  pend_valid_ff   <= 1'b1;
                  head_ff[trk_ff] <= nxt_head;
                  tail_ff[trk_ff] <= nxt_tail;
                  n_ff            <= n_ff - 1'b1;
                  state_ff        <= (n_ff == (QW+1)'(1)) ? S_FLUSH : S_RD;
               end
            end
            S_FLUSH: begin
               if (!pend_valid_ff) begin
                  state_ff <= S_PH;
               end else if (out_free) begin
                  out_ff        <= pend_ff;
                  out_trk_ff    <= 4'(trk_ff);
                  last_ff       <= 1'b1;
                  rsp_valid_ff  <= 1'b1;
                  pend_valid_ff <= 1'b0;
                  state_ff      <= S_PH;
               end
            end
            S_PH: begin
               if (phase_inc < {1'b0, cur_period}) begin
                  phase_ff[trk_ff] <= phase_inc[15:0];
                  state_ff         <= S_IDLE;
               end else begin
                  state_ff <= S_PHDIV;
               end
            end
            S_PHDIV: begin
               if (div_done) begin
                  phase_ff[trk_ff] <= div_r;
                  state_ff         <= S_IDLE;
               end
            end
            S_REC_CHK: begin
               if (rec_ok) begin
                  state_ff <= S_REC_DIV;
               end else if (32'(trk_ff) == NREC - 1) begin
                  state_ff <= S_CC;
               end else begin
                  trk_ff <= trk_ff + 1'b1;
               end
            end
            S_REC_DIV: begin
               if (div_done) begin
                  tail_ff[trk_ff] <= nxt_tail;
                  if (32'(trk_ff) == NREC - 1) begin
                     state_ff <= S_CC;
                  end else begin
                     trk_ff   <= trk_ff + 1'b1;
                     state_ff <= S_REC_CHK;
                  end
               end
            end
            S_CC: begin
               if (cc_ff) begin
                  rec_ff[ccbit_ff] <= ccv_ff;
               end
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready      = (state_ff == S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_play_track = out_trk_ff;
   assign rsp_play_port  = out_ff.port;
   assign rsp_play_size  = out_ff.size;
   assign rsp_play_a     = out_ff.a;
   assign rsp_play_b     = out_ff.b;
   assign rsp_play_c     = out_ff.c;
   assign rsp_last       = last_ff;

   `MLT_ASSERT_IMPLY(a_idle_no_pend, state_ff == S_IDLE, !pend_valid_ff)
   `MLT_ASSERT_IMPLY(a_div_idle, div_start, !div_busy)
   `MLT_ASSERT_NEXT(a_flush_done, state_ff == S_PH, !pend_valid_ff)
endmodule

### test/tb_midi_loop_track_sequencer.sv
// testbench for the loop track sequencer: directed table, then random requests
// checked against a behavioral track model; depends on mltseq_pkg and the rtl top
module tb_midi_loop_track_sequencer;

   localparam int NTRK  = 9;
   localparam int QDEP  = 64;
   localparam int LIMIT = 3000000;

   typedef struct packed {
      logic [3:0] trk;
      logic [3:0] port;
      logic [1:0] size;
      logic [7:0] a;
      logic [7:0] b;
      logic [7:0] c;
      logic       last;
   } play_type;

   typedef struct {
      mltseq_pkg::mode_type mode;
      logic [3:0]  trk;
      logic [3:0]  port;
      logic [7:0]  size;
      logic [7:0]  a;
      logic [7:0]  b;
      logic [7:0]  c;
      logic [15:0] per;
      int          n_play;
   } row_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [1:0]  req_mode = 0;
   logic [3:0]  req_track_sel = 0;
   logic [3:0]  req_in_port = 0;
   logic [7:0]  req_midi_size = 0;
   logic [7:0]  req_byte_a = 0;
   logic [7:0]  req_byte_b = 0;
   logic [7:0]  req_byte_c = 0;
   logic [15:0] req_new_period = 0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [3:0]  rsp_play_track;
   logic [3:0]  rsp_play_port;
   logic [1:0]  rsp_play_size;
   logic [7:0]  rsp_play_a;
   logic [7:0]  rsp_play_b;
   logic [7:0]  rsp_play_c;
   logic        rsp_last;

   mltseq_pkg::entry_type trk_store [NTRK][QDEP];
   logic [5:0]  trk_head [NTRK];
   logic [5:0]  trk_tail [NTRK];
   logic [15:0] trk_phase [NTRK];
   logic [15:0] trk_period [NTRK];
   logic [8:0]  rec_bits;

   play_type    plays_due [$];
   int          errors = 0;
   int          n_plays = 0;
   int          n_reqs = 0;
   int          cycles = 0;
   int          send_idle = 30;
   int          recv_idle = 78;

   midi_loop_track_sequencer i_dut (.*);

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("tb_midi_loop_track_sequencer: FAIL");
         $finish;
      end
   end

   task automatic report(input string what);
      $display("mismatch at cycle %0d: %s", cycles, what);
      errors++;
   endtask

   function automatic int queue_fill(input int t);
      return (trk_tail[t] >= trk_head[t]) ? trk_tail[t] - trk_head[t]
                                          : trk_tail[t] + QDEP - trk_head[t];
   endfunction

   // updates track state and queues expected plays; returns play count
   function automatic int play_model(input row_type r);
      int t, n, k;
      mltseq_pkg::entry_type e;
      logic [31:0] sc;
      play_type p;
      t = r.trk % NTRK;
      k = 0;
      case (r.mode)
         mltseq_pkg::MODE_TICK: begin
            n = queue_fill(t);
            while (n > 0) begin
               e = trk_store[t][trk_head[t]];
               sc = (32'(trk_period[t]) * 32'(e.rel)) >> mltseq_pkg::PHASE_BITS;
               if (sc != 32'(trk_phase[t])) break;
               p = '{trk: 4'(t), port: e.port, size: e.size, a: e.a, b: e.b, c: e.c,
                     last: 0};
               plays_due.push_back(p);
               trk_store[t][trk_tail[t]] = e;
               trk_head[t] = 6'((trk_head[t] + 1) % QDEP);
               trk_tail[t] = 6'((trk_tail[t] + 1) % QDEP);
               n--;
               k++;
            end
            if (k > 0) plays_due[$].last = 1;
            trk_phase[t] = 16'((32'(trk_phase[t]) + 1) % trk_period[t]);
         end
         mltseq_pkg::MODE_MIDI: begin
            if (r.size < 4) begin
               for (int i = 0; i < NTRK; i++) begin
                  if (rec_bits[i] && queue_fill(i) < QDEP - 1) begin
                     e.rel  = 16'((32'(trk_phase[i]) << mltseq_pkg::PHASE_BITS) /
                                  trk_period[i]);
                     e.size = r.size[1:0];
                     e.port = r.port;
                     e.a    = (r.size > 0) ? r.a : 8'd0;
                     e.b    = (r.size > 1) ? r.b : 8'd0;
                     e.c    = (r.size > 2) ? r.c : 8'd0;
                     trk_store[i][trk_tail[i]] = e;
                     trk_tail[i] = 6'((trk_tail[i] + 1) % QDEP);
                  end
               end
            end
            if (r.port == 0 && r.size == 3 && r.a == mltseq_pkg::CC_STATUS &&
                (r.b inside {[mltseq_pkg::CC_FIRST:mltseq_pkg::CC_LAST]}))
               rec_bits[r.b - mltseq_pkg::CC_FIRST] = (r.c != 0);
         end
         mltseq_pkg::MODE_CLEAR: begin
            trk_head[t] = 0;
            trk_tail[t] = 0;
         end
         default: if (r.per != 0) trk_period[t] = r.per;
      endcase
      return k;
   endfunction

   task automatic send(input row_type r);
      int k;
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid      <= 1;
      req_mode       <= r.mode;
      req_track_sel  <= r.trk;
      req_in_port    <= r.port;
      req_midi_size  <= r.size;
      req_byte_a     <= r.a;
      req_byte_b     <= r.b;
      req_byte_c     <= r.c;
      req_new_period <= r.per;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      k = play_model(r);
      if (r.n_play >= 0 && k != r.n_play)
         report($sformatf("request %0d: %0d plays due, table says %0d", n_reqs, k,
                          r.n_play));
      n_reqs++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         play_type got;
         got = '{rsp_play_track, rsp_play_port, rsp_play_size, rsp_play_a, rsp_play_b,
                 rsp_play_c, rsp_last};
         n_plays++;
         if (plays_due.size() == 0) report("play with none expected");
         else begin
            play_type want;
            want = plays_due.pop_front();
            if (got.trk != want.trk)   report($sformatf("track %0d/%0d", got.trk, want.trk));
            if (got.port != want.port) report($sformatf("port %0d/%0d", got.port, want.port));
            if (got.size != want.size) report($sformatf("size %0d/%0d", got.size, want.size));
            if (got.a != want.a)       report($sformatf("a %h/%h", got.a, want.a));
            if (got.b != want.b)       report($sformatf("b %h/%h", got.b, want.b));
            if (got.c != want.c)       report($sformatf("c %h/%h", got.c, want.c));
            if (got.last != want.last) report($sformatf("last %0d/%0d", got.last, want.last));
         end
      end
      rsp_ready <= ($urandom_range(99) >= recv_idle);
   end

   function automatic row_type mk(input mltseq_pkg::mode_type m, input int trk,
                                  input int port, input int size, input int a,
                                  input int b, input int c, input int per, input int np);
      row_type r;
      r = '{m, 4'(trk), 4'(port), 8'(size), 8'(a), 8'(b), 8'(c), 16'(per), np};
      return r;
   endfunction

   function automatic row_type rand_row();
      row_type r;
      int sel;
      sel = $urandom_range(99);
      r = mk(mltseq_pkg::MODE_TICK, $urandom_range(15), 0, 0, 0, 0, 0, 0, -1);
      r.port = $urandom_range(9) == 0 ? 4'($urandom_range(15)) : 4'd0;
      r.size = $urandom_range(19) == 0 ? 8'($urandom_range(255)) : 8'($urandom_range(3));
      r.a = 8'($urandom_range(255));
      r.b = 8'($urandom_range(255));
      r.c = 8'($urandom_range(255));
      r.per = $urandom_range(15) == 0 ? 16'($urandom) : 16'($urandom_range(8));
      if (sel < 55) r.mode = mltseq_pkg::MODE_TICK;
      else if (sel < 80) r.mode = mltseq_pkg::MODE_MIDI;
      else if (sel < 90) begin
         r.mode = mltseq_pkg::MODE_MIDI;
         r.port = 4'd0;
         r.size = 8'd3;
         r.a = mltseq_pkg::CC_STATUS;
         r.b = 8'($urandom_range(mltseq_pkg::CC_LAST + 1, mltseq_pkg::CC_FIRST - 1));
         r.c = ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom_range(255));
      end else if (sel < 94) r.mode = mltseq_pkg::MODE_CLEAR;
      else r.mode = mltseq_pkg::MODE_PERIOD;
      return r;
   endfunction

   row_type dir_rows [$];

   initial begin
      for (int t = 0; t < NTRK; t++) begin
         trk_head[t] = 0;
         trk_tail[t] = 0;
         trk_phase[t] = 0;
         trk_period[t] = mltseq_pkg::DEFAULT_PERIOD;
      end
      rec_bits = 0;
      dir_rows = '{
         mk(mltseq_pkg::MODE_TICK, 0, 0, 0, 0, 0, 0, 0, 0),
         mk(mltseq_pkg::MODE_PERIOD, 0, 0, 0, 0, 0, 0, 0, 0),
         mk(mltseq_pkg::MODE_MIDI, 0, 0, 3, 8'hB0, 23, 1, 0, 0),
         mk(mltseq_pkg::MODE_MIDI, 0, 0, 3, 8'hB0, 31, 8'hFF, 0, 0),
         mk(mltseq_pkg::MODE_MIDI, 0, 0, 3, 8'hB0, 22, 1, 0, 0),
         mk(mltseq_pkg::MODE_MIDI, 0, 0, 3, 8'hB0, 32, 1, 0, 0),
         mk(mltseq_pkg::MODE_MIDI, 0, 5, 3, 8'h90, 60, 127, 0, 0),
         mk(mltseq_pkg::MODE_MIDI, 0, 15, 0, 8'hFF, 8'hFF, 8'hFF, 0, 0),
         mk(mltseq_pkg::MODE_MIDI, 0, 1, 200, 8'h90, 1, 1, 0, 0),
         mk(mltseq_pkg::MODE_TICK, 9, 0, 0, 0, 0, 0, 0, -1),
         mk(mltseq_pkg::MODE_TICK, 0, 0, 0, 0, 0, 0, 0, 0),
         mk(mltseq_pkg::MODE_PERIOD, 0, 0, 0, 0, 0, 0, 1, 0),
         mk(mltseq_pkg::MODE_TICK, 0, 0, 0, 0, 0, 0, 0, -1),
         mk(mltseq_pkg::MODE_TICK, 0, 0, 0, 0, 0, 0, 0, -1),
         mk(mltseq_pkg::MODE_PERIOD, 8, 0, 0, 0, 0, 0, 16'hFFFF, 0),
         mk(mltseq_pkg::MODE_MIDI, 0, 2, 1, 8'hF8, 0, 0, 0, 0),
         mk(mltseq_pkg::MODE_TICK, 8, 0, 0, 0, 0, 0, 0, -1),
         mk(mltseq_pkg::MODE_MIDI, 0, 0, 3, 8'hB0, 23, 0, 0, 0),
         mk(mltseq_pkg::MODE_CLEAR, 9, 0, 0, 0, 0, 0, 0, 0),
         mk(mltseq_pkg::MODE_TICK, 0, 0, 0, 0, 0, 0, 0, 0),
         mk(mltseq_pkg::MODE_TICK, 15, 0, 0, 0, 0, 0, 0, -1),
         mk(mltseq_pkg::MODE_CLEAR, 15, 0, 0, 0, 0, 0, 0, 0)
      };
      repeat (9) @(posedge clock);
      reset <= 0;
      foreach (dir_rows[i]) send(dir_rows[i]);
      // fill track 1 past capacity to reach the full queue case
      send(mk(mltseq_pkg::MODE_MIDI, 0, 0, 3, 8'hB0, 24, 1, 0, 0));
      repeat (66) send(mk(mltseq_pkg::MODE_MIDI, 0, 3, 2, 8'h80, $urandom_range(255),
                          0, 0, 0));
      send(mk(mltseq_pkg::MODE_MIDI, 0, 0, 3, 8'hB0, 24, 0, 0, 0));
      send(mk(mltseq_pkg::MODE_TICK, 1, 0, 0, 0, 0, 0, 0, -1));
      for (int i = 0; i < 390; i++) begin
         if (i == 130) begin
            send_idle = 78;
            recv_idle = 30;
         end else if (i == 260) begin
            send_idle = 0;
            recv_idle = 0;
         end
         send(rand_row());
      end
      req_valid <= 0;
      while (plays_due.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      $display("covered %0d requests, %0d plays checked, idle mixes on both sides",
               n_reqs, n_plays);
      if (errors == 0) $display("tb_midi_loop_track_sequencer: PASS");
      else $display("tb_midi_loop_track_sequencer: FAIL");
      $finish;
   end
endmodule

### files.f
+incdir+rtl
rtl/mltseq_pkg.sv
rtl/mltseq_evs.sv
rtl/mltseq_div.sv
rtl/midi_loop_track_sequencer.sv
test/tb_midi_loop_track_sequencer.sv
